// File: hdl/lcat_pkg.sv
// ----------------------------------------------------------------------------
// lcat_pkg
// shared types, codes and constants for the load cell converter reader
// ----------------------------------------------------------------------------
package lcat_pkg;

    // fixed field widths
    localparam int OP_W      = 2;
    localparam int SAMPLES_W = 16;
    localparam int RAW_W     = 24;
    localparam int WEIGHT_W  = 56;
    localparam int TIMEOUT_W = 20;
    localparam int HALF_W    = 8;
    localparam int GAIN_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int ARITH_W   = WEIGHT_W;

    // parameter defaults
    localparam int SAMPLE_BITS_DEF     = 24;
    localparam int TARE_COUNT_BITS_DEF = 16;

    // register reset values
    localparam logic [TIMEOUT_W-1:0]     TIMEOUT_RST = TIMEOUT_W'(1000);
    localparam logic [HALF_W-1:0]        HALF_RST    = HALF_W'(2);
    localparam logic signed [GAIN_W-1:0] GAIN_RST    = GAIN_W'(65536);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_READY_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN          = 2'd2;

    // command codes
    localparam logic [OP_W-1:0] OP_TICK = 2'd0;
    localparam logic [OP_W-1:0] OP_READ = 2'd1;
    localparam logic [OP_W-1:0] OP_TARE = 2'd2;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_READ,
        MODE_TARE
    } mode_t;

    typedef enum logic [1:0] {
        TK_IDLE,
        TK_ARITH,
        TK_EMIT
    } tick_state_t;

    typedef enum logic [2:0] {
        AR_IDLE,
        AR_MUL,
        AR_DNEG,
        AR_DIV,
        AR_QNEG,
        AR_DONE
    } arith_state_t;

    typedef struct packed {
        logic                 start;
        logic                 do_mul;
        logic                 do_div;
    } arith_req_t;

    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic                 dout_level;
        logic [SAMPLES_W-1:0] tare_samples;
    } tick_in_t;

    typedef struct packed {
        logic                       sclk_level;
        logic                       busy_res;
        logic                       sample_valid;
        logic signed [RAW_W-1:0]    raw_value;
        logic signed [WEIGHT_W-1:0] weight_scaled;
        logic                       read_timeout;
        logic                       tare_done;
        logic                       tare_ok;
    } tick_out_t;

endpackage

// File: hdl/lcat_arith.sv
// ----------------------------------------------------------------------------
// lcat_arith
// shared add/subtract unit stepped as shift-add multiplier and restoring divider
// ----------------------------------------------------------------------------
module lcat_arith
    import lcat_pkg::*;
#(
    parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
    parameter int TARE_COUNT_BITS = TARE_COUNT_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  arith_req_t                        req,
    input  logic [ARITH_W-1:0]                mcand,
    input  logic signed [GAIN_W-1:0]          gain,
    input  logic signed [SAMPLE_BITS+TARE_COUNT_BITS-1:0] dividend,
    input  logic [TARE_COUNT_BITS-1:0]        divisor,
    output logic                              done,
    output logic [ARITH_W-1:0]                product,
    output logic [SAMPLE_BITS-1:0]            quotient
);

    localparam int SW        = SAMPLE_BITS + TARE_COUNT_BITS;
    localparam int CW        = TARE_COUNT_BITS;
    localparam int MAX_STEPS = (SW > GAIN_W) ? SW : GAIN_W;
    localparam int STEP_W    = $clog2(MAX_STEPS);

    arith_state_t        state_reg, state_next;
    logic [ARITH_W-1:0]  acc_reg, acc_next;
    logic [ARITH_W-1:0]  mcand_reg, mcand_next;
    logic [GAIN_W-1:0]   mplier_reg, mplier_next;
    logic [SW-1:0]       quo_reg, quo_next;
    logic [CW-1:0]       rem_reg, rem_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                div_reg, div_next;

    logic [ARITH_W-1:0]  alu_a, alu_b, alu_res;
    logic                alu_sub;
    logic [CW:0]         trial;
    logic                mul_last, div_last;

    assign mul_last = (step_reg == STEP_W'(GAIN_W-1));
    assign div_last = (step_reg == STEP_W'(SW-1));
    assign trial    = {rem_reg, quo_reg[SW-1]};

    // the one adder
    assign alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            AR_IDLE:
            begin
                if (req.start)
                begin
                    if (req.do_mul)
                        state_next = AR_MUL;
                    else if (req.do_div)
                        state_next = AR_DNEG;
                    else
                        state_next = AR_DONE;
                end
            end
            AR_MUL:
            begin
                if (mul_last)
                    state_next = div_reg ? AR_DNEG : AR_DONE;
            end
            AR_DNEG:  state_next = AR_DIV;
            AR_DIV:
            begin
                if (div_last)
                    state_next = AR_QNEG;
            end
            AR_QNEG:  state_next = AR_DONE;
            AR_DONE:  state_next = AR_IDLE;
            default:  state_next = AR_IDLE;
        endcase
    end

    always_comb
    begin
        alu_a       = '0;
        alu_b       = '0;
        alu_sub     = 1'b0;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        step_next   = step_reg;
        div_next    = div_reg;
        case (state_reg)
            AR_IDLE:
            begin
                if (req.start)
                begin
                    acc_next    = '0;
                    mcand_next  = mcand;
                    mplier_next = gain;
                    step_next   = '0;
                    div_next    = req.do_div;
                end
            end
            AR_MUL:
            begin
                // top bit of the gain carries negative weight
                alu_a       = acc_reg;
                alu_b       = mplier_reg[0] ? mcand_reg : '0;
                alu_sub     = mul_last;
                acc_next    = alu_res;
                mcand_next  = {mcand_reg[ARITH_W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[GAIN_W-1:1]};
                step_next   = step_reg + 1'b1;
            end
            AR_DNEG:
            begin
                // magnitude of the sum
                alu_sub   = 1'b1;
                alu_b     = ARITH_W'(dividend);
                quo_next  = dividend[SW-1] ? alu_res[SW-1:0] : dividend;
                rem_next  = '0;
                step_next = '0;
            end
            AR_DIV:
            begin
                alu_a     = ARITH_W'(trial);
                alu_b     = ARITH_W'(divisor);
                alu_sub   = 1'b1;
                rem_next  = alu_res[ARITH_W-1] ? trial[CW-1:0] : alu_res[CW-1:0];
                quo_next  = {quo_reg[SW-2:0], ~alu_res[ARITH_W-1]};
                step_next = step_reg + 1'b1;
            end
            AR_QNEG:
            begin
                alu_sub = 1'b1;
                alu_b   = ARITH_W'(quo_reg);
                if (dividend[SW-1])
                    quo_next = alu_res[SW-1:0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= AR_IDLE;
            step_reg  <= '0;
            div_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            div_reg   <= div_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
    end

    assign done     = (state_reg == AR_DONE);
    assign product  = acc_reg;
    assign quotient = quo_reg[SAMPLE_BITS-1:0];

    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> state_reg == AR_IDLE)
        else $error("arith start while busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("arith done held");

    a_div_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == AR_MUL && mul_last && div_reg) |=> state_reg == AR_DNEG)
        else $error("division skipped after multiply");

endmodule

// File: hdl/load_cell_adc_reader_tare_top.sv
// ----------------------------------------------------------------------------
// load_cell_adc_reader_tare_top
// tick-driven bit-banged 24-bit converter readout with tare and gain scaling
// ----------------------------------------------------------------------------
// Every input item is one time tick carrying the data-out pin level and a
// command; every tick gives exactly one result item with the serial clock level
// to drive, the busy flag and any read, timeout or tare events. The tick's
// control work (wait for ready, pulse timing, bit shifting, tare bookkeeping)
// is done in the cycle the item is accepted; an ordinary tick goes straight
// into the output register when that register is free. A finished read runs
// the weight product (raw minus offset, times gain) through lcat_arith, a
// shift-add sequencer on one shared 56-bit adder, one gain bit per cycle. The
// tick that ends a tare with samples collected also divides the sum by the
// count, one quotient bit per cycle on the same adder. The input side is not
// ready while the sequencer runs; a result waits in the output register while
// the next item is taken. Configuration writes are taken at any time and
// should only be made while the block is idle.
module load_cell_adc_reader_tare_top
    import lcat_pkg::*;
#(
    parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
    parameter int TARE_COUNT_BITS = TARE_COUNT_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  tick_in_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output tick_out_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SB     = SAMPLE_BITS;
    localparam int CW     = TARE_COUNT_BITS;
    localparam int SW     = SB + CW;
    localparam int DIFF_W = SB + 1;
    localparam int BC_W   = $clog2(SB + 2);
    localparam int REXT_W = (SB > RAW_W) ? SB : RAW_W;

    // configuration registers
    logic [TIMEOUT_W-1:0]      timeout_reg;
    logic [HALF_W-1:0]         half_reg;
    logic signed [GAIN_W-1:0]  gain_reg;

    // converter state
    mode_t                     mode_reg, mode_next;
    logic                      waiting_reg, waiting_next;
    logic [TIMEOUT_W-1:0]      phase_reg, phase_next;
    logic [BC_W-1:0]           bc_reg, bc_next;
    logic                      ch_reg, ch_next;
    logic [SB-1:0]             shift_reg, shift_next;
    logic signed [SB-1:0]      offset_reg;
    logic signed [SW-1:0]      sum_reg, sum_next;
    logic [CW-1:0]             att_reg, att_next;
    logic [CW-1:0]             coll_reg, coll_next;

    // tick sequencing
    tick_state_t               tk_state_reg, tk_state_next;
    tick_out_t                 res_reg, res_next;
    tick_out_t                 out_reg;
    logic                      out_valid_reg;
    logic signed [DIFF_W-1:0]  diff_reg, diff_next;
    logic                      start_reg, mul_reg, div_reg;

    logic                      in_fire, out_free, need_mul, need_div, need_arith;
    logic                      load_direct, load_pend;
    logic                      end_attempt;
    logic [SB-1:0]             sample_word;
    logic signed [REXT_W-1:0]  raw_ext;
    logic [CW-1:0]             samples;

    arith_req_t                arith_req;
    logic                      arith_done;
    logic [ARITH_W-1:0]        arith_product;
    logic [SB-1:0]             arith_quotient;

    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign samples   = in_data.tare_samples[CW-1:0];

    // one tick of the converter protocol
    always_comb
    begin
        mode_next    = mode_reg;
        waiting_next = waiting_reg;
        phase_next   = phase_reg;
        bc_next      = bc_reg;
        ch_next      = ch_reg;
        shift_next   = shift_reg;
        sum_next     = sum_reg;
        att_next     = att_reg;
        coll_next    = coll_reg;
        res_next     = '0;
        need_mul     = 1'b0;
        need_div     = 1'b0;
        end_attempt  = 1'b0;
        sample_word  = shift_reg;
        raw_ext      = '0;

        // start of an operation also starts the wait for ready
        if (mode_reg == MODE_IDLE)
        begin
            if (in_data.op == OP_READ)
            begin
                mode_next    = MODE_READ;
                waiting_next = 1'b1;
                phase_next   = '0;
                bc_next      = '0;
                ch_next      = 1'b0;
                shift_next   = '0;
            end
            else if (in_data.op == OP_TARE)
            begin
                sum_next  = '0;
                coll_next = '0;
                att_next  = samples;
                if (samples == '0)
                    res_next.tare_done = 1'b1;
                else
                begin
                    mode_next    = MODE_TARE;
                    waiting_next = 1'b1;
                    phase_next   = '0;
                    bc_next      = '0;
                    ch_next      = 1'b0;
                    shift_next   = '0;
                end
            end
        end

        if (mode_next != MODE_IDLE)
        begin
            if (waiting_next)
            begin
                // timeout wins over a ready pin on the same tick
                if (phase_next >= timeout_reg)
                begin
                    res_next.read_timeout = 1'b1;
                    if (mode_next == MODE_TARE)
                        end_attempt = 1'b1;
                    else
                    begin
                        mode_next    = MODE_IDLE;
                        waiting_next = 1'b0;
                    end
                end
                else if (!in_data.dout_level)
                begin
                    waiting_next = 1'b0;
                    phase_next   = '0;
                    bc_next      = '0;
                    ch_next      = 1'b1;
                    shift_next   = '0;
                end
                else
                    phase_next = phase_next + 1'b1;
            end
            else
            begin
                res_next.sclk_level = ch_next;
                phase_next = phase_next + 1'b1;
                if (phase_next >= TIMEOUT_W'(half_reg))
                begin
                    phase_next = '0;
                    if (ch_next)
                        ch_next = 1'b0;
                    else
                    begin
                        // sample after the falling edge, msb first
                        if (bc_next < BC_W'(SB))
                            shift_next = {shift_next[SB-2:0], in_data.dout_level};
                        bc_next = bc_next + 1'b1;
                        if (bc_next >= BC_W'(SB + 1))
                        begin
                            sample_word           = shift_next;
                            raw_ext               = REXT_W'(signed'(shift_next));
                            need_mul              = 1'b1;
                            res_next.sample_valid = 1'b1;
                            res_next.raw_value    = raw_ext[RAW_W-1:0];
                            if (mode_next == MODE_TARE)
                            begin
                                sum_next    = sum_next + SW'(signed'(shift_next));
                                coll_next   = coll_next + 1'b1;
                                end_attempt = 1'b1;
                            end
                            else
                                mode_next = MODE_IDLE;
                        end
                        else
                            ch_next = 1'b1;
                    end
                end
            end
        end

        // end of one tare attempt
        if (end_attempt)
        begin
            if (att_next != '0)
                att_next = att_next - 1'b1;
            if (att_next != '0)
            begin
                waiting_next = 1'b1;
                phase_next   = '0;
                bc_next      = '0;
                ch_next      = 1'b0;
                shift_next   = '0;
            end
            else
            begin
                res_next.tare_done = 1'b1;
                if (coll_next != '0)
                begin
                    res_next.tare_ok = 1'b1;
                    need_div         = 1'b1;
                end
                mode_next    = MODE_IDLE;
                waiting_next = 1'b0;
            end
        end

        res_next.busy_res = (mode_next != MODE_IDLE);
    end

    // difference against the offset held before this tick
    assign diff_next  = DIFF_W'(signed'(sample_word)) - DIFF_W'(offset_reg);
    assign need_arith = need_mul || need_div;

    // tick sequencer: next state
    always_comb
    begin
        tk_state_next = tk_state_reg;
        case (tk_state_reg)
            TK_IDLE:
            begin
                if (in_fire)
                begin
                    if (need_arith)
                        tk_state_next = TK_ARITH;
                    else if (!out_free)
                        tk_state_next = TK_EMIT;
                end
            end
            TK_ARITH:
            begin
                if (arith_done)
                    tk_state_next = TK_EMIT;
            end
            TK_EMIT:
            begin
                if (out_free)
                    tk_state_next = TK_IDLE;
            end
            default: tk_state_next = TK_IDLE;
        endcase
    end

    // tick sequencer: outputs
    always_comb
    begin
        in_ready    = (tk_state_reg == TK_IDLE);
        load_direct = 1'b0;
        load_pend   = 1'b0;
        case (tk_state_reg)
            TK_IDLE:  load_direct = in_fire && !need_arith && out_free;
            TK_EMIT:  load_pend   = out_free;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= TIMEOUT_RST;
            half_reg      <= HALF_RST;
            gain_reg      <= GAIN_RST;
            mode_reg      <= MODE_IDLE;
            waiting_reg   <= 1'b0;
            phase_reg     <= '0;
            bc_reg        <= '0;
            ch_reg        <= 1'b0;
            shift_reg     <= '0;
            offset_reg    <= '0;
            sum_reg       <= '0;
            att_reg       <= '0;
            coll_reg      <= '0;
            tk_state_reg  <= TK_IDLE;
            out_valid_reg <= 1'b0;
            start_reg     <= 1'b0;
            mul_reg       <= 1'b0;
            div_reg       <= 1'b0;
        end
        else
        begin
            tk_state_reg <= tk_state_next;
            start_reg    <= in_fire && need_arith;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_READY_TIMEOUT: timeout_reg <= cfg_data[TIMEOUT_W-1:0];
                    CFG_HALF_PERIOD:   half_reg    <= cfg_data[HALF_W-1:0];
                    CFG_GAIN:          gain_reg    <= signed'(cfg_data[GAIN_W-1:0]);
                    default:
                    begin
                    end
                endcase
            end

            if (in_fire)
            begin
                mode_reg    <= mode_next;
                waiting_reg <= waiting_next;
                phase_reg   <= phase_next;
                bc_reg      <= bc_next;
                ch_reg      <= ch_next;
                shift_reg   <= shift_next;
                sum_reg     <= sum_next;
                att_reg     <= att_next;
                coll_reg    <= coll_next;
                mul_reg     <= need_mul;
                div_reg     <= need_div;
            end

            // new offset from the tare average
            if (arith_done && div_reg)
                offset_reg <= signed'(arith_quotient);

            if (load_direct || load_pend)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            res_reg  <= res_next;
            diff_reg <= diff_next;
        end
        else if (arith_done && mul_reg)
            res_reg.weight_scaled <= signed'(arith_product[WEIGHT_W-1:0]);

        if (load_direct)
            out_reg <= res_next;
        else if (load_pend)
            out_reg <= res_reg;
    end

    assign arith_req = '{start: start_reg, do_mul: mul_reg, do_div: div_reg};

    lcat_arith #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .TARE_COUNT_BITS (TARE_COUNT_BITS)
    ) u_arith (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (arith_req),
        .mcand    (ARITH_W'(diff_reg)),
        .gain     (gain_reg),
        .dividend (sum_reg),
        .divisor  (coll_reg),
        .done     (arith_done),
        .product  (arith_product),
        .quotient (arith_quotient)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_done_in_arith: assert property (@(posedge clk) disable iff (!rst_n)
        arith_done |-> tk_state_reg == TK_ARITH)
        else $error("arith result outside arith state");

    a_idle_not_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_IDLE) |-> !waiting_reg)
        else $error("waiting flag set while idle");

    a_ok_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!out_reg.tare_ok || out_reg.tare_done))
        else $error("tare ok without tare done");

    a_no_timeout_and_sample: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.sample_valid && out_reg.read_timeout))
        else $error("sample and timeout on one tick");

endmodule

// File: dv/load_cell_adc_reader_tare_top_tb.sv
// ----------------------------------------------------------------------------
// load_cell_adc_reader_tare_top_tb
// self-checking bench for the tick-driven converter reader with tare
// ----------------------------------------------------------------------------
// A queue of pending ticks feeds a valid/ready driver; a monitor predicts one
// result item per accepted tick with a local model of the reader and compares
// every accepted result, field by field, with the oldest prediction. Phases
// are separated by register writes made only once the reader is idle. A short
// directed part covers sample extremes, empty, failed and rounding tares,
// immediate and late timeouts, zero and longer half periods, the widest
// timeout and a long tare of timeouts; random phases then run reads, tares
// and noise under random register settings with random gaps on both handshakes.
// ----------------------------------------------------------------------------
module load_cell_adc_reader_tare_top_tb;
    import lcat_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          NBITS        = SAMPLE_BITS_DEF;
    localparam int          IDLE_PCT     = 22;
    localparam int          QUIET_LIMIT  = 3000;
    localparam int          END_CYCLES   = 200;
    localparam int          RANDOM_TICKS = 400;
    localparam logic [1:0]  OP_SPARE     = 2'd3;

    // clock, reset and block ports, all known from time zero
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    tick_in_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    tick_out_t             out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // stimulus and checking bookkeeping
    tick_in_t    pending_ticks[$];
    tick_out_t   predicted_results[$];
    int unsigned items_pushed = 0;
    int unsigned results_seen = 0;
    int unsigned fails        = 0;
    int unsigned quiet_cycles = 0;
    bit          calm         = 1'b0;
    tick_out_t   expected_item;
    tick_out_t   oldest_item;

    // local copy of the register file
    logic [TIMEOUT_W-1:0]     reg_timeout = TIMEOUT_RST;
    logic [HALF_W-1:0]        reg_half    = HALF_RST;
    logic signed [GAIN_W-1:0] reg_gain    = GAIN_RST;

    // local copy of the reader state, reset values
    mode_t             rd_mode      = MODE_IDLE;
    bit                rd_waiting   = 1'b0;
    int unsigned       rd_phase     = 0;
    int unsigned       rd_bits      = 0;
    bit                rd_sclk      = 1'b0;
    logic [RAW_W-1:0]  rd_shift     = '0;
    longint            rd_offset    = 0;
    longint            rd_tare_sum  = 0;
    int unsigned       rd_attempts  = 0;
    int unsigned       rd_collected = 0;

    load_cell_adc_reader_tare_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------------
    // reader model
    // ------------------------------------------------------------------------

    // fresh wait for data-out low
    function automatic void start_wait();
        rd_waiting = 1'b1;
        rd_phase   = 0;
        rd_bits    = 0;
        rd_sclk    = 1'b0;
        rd_shift   = '0;
    endfunction

    // one tare attempt is over; returns {tare finished, offset updated}
    function automatic logic [1:0] close_attempt();
        logic [1:0] flags;
        flags = 2'b00;
        if (rd_attempts > 0)
        begin
            rd_attempts--;
        end
        if (rd_attempts != 0)
        begin
            start_wait();
        end
        else
        begin
            flags[1] = 1'b1;
            // average truncated toward zero, offset kept when nothing came in
            if (rd_collected != 0)
            begin
                rd_offset = rd_tare_sum / longint'(rd_collected);
                flags[0] = 1'b1;
            end
            rd_mode    = MODE_IDLE;
            rd_waiting = 1'b0;
        end
        return flags;
    endfunction

    // advance the model by one tick and return the result item it gives
    function automatic tick_out_t advance_reader(input tick_in_t t);
        tick_out_t               r;
        logic [1:0]              ends;
        logic signed [RAW_W-1:0] raw_s;
        longint                  raw_l;
        longint                  w;
        r    = '0;
        ends = 2'b00;
        // commands only count while idle
        if (rd_mode == MODE_IDLE)
        begin
            if (t.op == OP_READ)
            begin
                rd_mode = MODE_READ;
                start_wait();
            end
            else if (t.op == OP_TARE)
            begin
                rd_tare_sum  = 0;
                rd_collected = 0;
                rd_attempts  = t.tare_samples;
                if (t.tare_samples == '0)
                begin
                    r.tare_done = 1'b1;
                end
                else
                begin
                    rd_mode = MODE_TARE;
                    start_wait();
                end
            end
        end
        if (rd_mode != MODE_IDLE)
        begin
            if (rd_waiting)
            begin
                // the timeout is checked before the pin, even on the start tick
                if (rd_phase >= reg_timeout)
                begin
                    r.read_timeout = 1'b1;
                    if (rd_mode == MODE_TARE)
                    begin
                        ends = close_attempt();
                    end
                    else
                    begin
                        rd_mode    = MODE_IDLE;
                        rd_waiting = 1'b0;
                    end
                end
                else if (!t.dout_level)
                begin
                    rd_waiting = 1'b0;
                    rd_phase   = 0;
                    rd_bits    = 0;
                    rd_sclk    = 1'b1;
                    rd_shift   = '0;
                end
                else
                begin
                    rd_phase++;
                end
            end
            else
            begin
                r.sclk_level = rd_sclk;
                rd_phase++;
                // a half period of zero behaves as one
                if (rd_phase >= reg_half)
                begin
                    rd_phase = 0;
                    if (rd_sclk)
                    begin
                        rd_sclk = 1'b0;
                    end
                    else
                    begin
                        if (rd_bits < NBITS)
                        begin
                            rd_shift = {rd_shift[RAW_W-2:0], t.dout_level};
                        end
                        rd_bits++;
                        if (rd_bits >= NBITS + 1)
                        begin
                            raw_s = rd_shift;
                            raw_l = raw_s;
                            w     = (raw_l - rd_offset) * longint'(reg_gain);
                            r.sample_valid  = 1'b1;
                            r.raw_value     = raw_s;
                            r.weight_scaled = w[WEIGHT_W-1:0];
                            if (rd_mode == MODE_TARE)
                            begin
                                rd_tare_sum += raw_l;
                                rd_collected++;
                                ends = close_attempt();
                            end
                            else
                            begin
                                rd_mode = MODE_IDLE;
                            end
                        end
                        else
                        begin
                            rd_sclk = 1'b1;
                        end
                    end
                end
            end
        end
        r.tare_done = r.tare_done | ends[1];
        r.tare_ok   = ends[0];
        r.busy_res  = (rd_mode != MODE_IDLE);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // driver: tick items from the pending queue, random gaps between them
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (pending_ticks.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                in_valid <= 1'b1;
                in_data  <= pending_ticks.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // result side stalls at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endtask

    // ------------------------------------------------------------------------
    // monitor: predict on input acceptance, then check on output acceptance
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // prediction first so a same-edge result always finds its item
            if (in_valid && in_ready)
            begin
                expected_item = advance_reader(in_data);
                predicted_results.push_back(expected_item);
            end
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (predicted_results.size() == 0)
                begin
                    $error("result item with no prediction waiting");
                    fails++;
                end
                else
                begin
                    oldest_item = predicted_results.pop_front();
                    check_field("sclk_level", oldest_item.sclk_level, out_data.sclk_level);
                    check_field("busy_res", oldest_item.busy_res, out_data.busy_res);
                    check_field("sample_valid", oldest_item.sample_valid,
                                out_data.sample_valid);
                    check_field("raw_value", oldest_item.raw_value, out_data.raw_value);
                    check_field("weight_scaled", oldest_item.weight_scaled,
                                out_data.weight_scaled);
                    check_field("read_timeout", oldest_item.read_timeout,
                                out_data.read_timeout);
                    check_field("tare_done", oldest_item.tare_done, out_data.tare_done);
                    check_field("tare_ok", oldest_item.tare_ok, out_data.tare_ok);
                end
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_tick(input logic [1:0] op, input logic dout, input logic [15:0] n);
        tick_in_t t;
        t.op           = op;
        t.dout_level   = dout;
        t.tare_samples = n;
        pending_ticks.push_back(t);
        items_pushed++;
    endtask

    // tick sent while busy: op ignored, tare count kept small in case it is not
    task automatic queue_filler(input logic dout);
        logic [1:0]  op;
        logic [15:0] n;
        op = 2'($urandom_range(0, 3));
        n  = (op == OP_TARE) ? 16'($urandom_range(0, 3)) : 16'($urandom);
        queue_tick(op, dout, n);
    endtask

    // one read attempt: optional lead command, wait for ready, 25 pulses unless it fails
    task automatic queue_attempt(input bit lead, input logic [1:0] op, input logic [15:0] n,
                                 input logic [23:0] word, input int waitn, input bit fail);
        int hp;
        int i;
        int k;
        logic dout;
        hp = (reg_half == 0) ? 1 : int'(reg_half);
        if (reg_timeout == 0)
        begin
            fail = 1'b1;
        end
        if (fail)
        begin
            // pin held high until the wait runs out
            for (i = 0; i <= int'(reg_timeout); i++)
            begin
                if (i == 0 && lead)
                    queue_tick(op, 1'b1, n);
                else
                    queue_filler(1'b1);
            end
        end
        else
        begin
            if (waitn >= int'(reg_timeout))
            begin
                waitn = int'(reg_timeout) - 1;
            end
            for (i = 0; i <= waitn; i++)
            begin
                dout = (i == waitn) ? 1'b0 : 1'b1;
                if (i == 0 && lead)
                    queue_tick(op, dout, n);
                else
                    queue_filler(dout);
            end
            // data bit held for the whole pulse, msb first, then the extra pulse
            for (k = 0; k <= NBITS; k++)
            begin
                for (i = 0; i < 2 * hp; i++)
                begin
                    dout = (k < NBITS) ? word[NBITS-1-k] : 1'($urandom);
                    queue_filler(dout);
                end
            end
        end
    endtask

    function automatic logic [23:0] pick_word();
        int sel;
        sel = $urandom_range(0, 7);
        case (sel)
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'hFFFFFF;
            3: return 24'h000000;
            default: return 24'($urandom);
        endcase
    endfunction

    // register write, valid left high for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_READY_TIMEOUT)
            reg_timeout = val[TIMEOUT_W-1:0];
        else if (idx == CFG_HALF_PERIOD)
            reg_half = val[HALF_W-1:0];
        else if (idx == CFG_GAIN)
            reg_gain = val[GAIN_W-1:0];
    endtask

    task automatic set_regs(input logic [31:0] timeout, input logic [31:0] half,
                            input logic [31:0] gain);
        write_reg(CFG_READY_TIMEOUT, timeout);
        write_reg(CFG_HALF_PERIOD, half);
        write_reg(CFG_GAIN, gain);
        cfg_valid <= 1'b0;
    endtask

    // wait for every result, then plain ticks until the reader is idle
    task automatic settle_idle();
        bit busy;
        int k;
        busy = 1'b1;
        while (busy)
        begin
            while (results_seen != items_pushed)
                @(posedge clk);
            if (rd_mode == MODE_IDLE)
            begin
                busy = 1'b0;
            end
            else
            begin
                for (k = 0; k < 32; k++)
                begin
                    queue_tick(($urandom_range(0, 1) != 0) ? OP_TICK : OP_SPARE,
                               1'($urandom), 16'($urandom));
                end
            end
        end
    endtask

    task automatic queue_random_tare(input int n);
        int a;
        bit fail;
        for (a = 0; a < n; a++)
        begin
            fail = (reg_timeout <= 30) && ($urandom_range(0, 3) == 0);
            queue_attempt(a == 0, OP_TARE, 16'(n), pick_word(), $urandom_range(0, 3), fail);
        end
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned rnd_base;
        int          phase_no;
        int          j;
        int          sel;
        logic [31:0] timeout;
        logic [31:0] half;
        logic [31:0] gain;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values: sample extremes, empty tare, rounding tare
        queue_attempt(1'b1, OP_READ, 16'h0000, 24'h7FFFFF, 0, 1'b0);
        queue_attempt(1'b1, OP_READ, 16'hFFFF, 24'h800000, 3, 1'b0);
        queue_attempt(1'b1, OP_READ, 16'h5A5A, 24'hFFFFFF, 1, 1'b0);
        queue_attempt(1'b1, OP_READ, 16'h0000, 24'h000000, 0, 1'b0);
        queue_tick(OP_SPARE, 1'b1, 16'hFFFF);
        queue_tick(OP_TICK, 1'b0, 16'h0000);
        queue_tick(OP_TARE, 1'b1, 16'h0000);
        queue_attempt(1'b1, OP_TARE, 16'd3, 24'h000123, 0, 1'b0);
        queue_attempt(1'b0, OP_TICK, 16'd0, 24'hFFF000, 2, 1'b0);
        queue_attempt(1'b0, OP_TICK, 16'd0, 24'h000FFF, 0, 1'b0);
        queue_attempt(1'b1, OP_READ, 16'h0000, 24'h400000, 0, 1'b0);
        settle_idle();

        // zero timeout fails at once; tare with nothing collected keeps offset
        set_regs(32'd0, 32'd1, 32'h8000_0000);
        queue_tick(OP_READ, 1'b0, 16'h0000);
        queue_attempt(1'b1, OP_TARE, 16'd2, 24'h0, 0, 1'b1);
        queue_attempt(1'b0, OP_TICK, 16'd0, 24'h0, 0, 1'b1);
        settle_idle();

        // zero half period, late timeout, tare average of -3 and 0 goes to -1
        set_regs(32'd5, 32'd0, 32'h7FFF_FFFF);
        queue_attempt(1'b1, OP_READ, 16'h0000, 24'h0, 0, 1'b1);
        queue_attempt(1'b1, OP_TARE, 16'd3, 24'h0, 0, 1'b1);
        queue_attempt(1'b0, OP_TICK, 16'd0, 24'hFFFFFD, 1, 1'b0);
        queue_attempt(1'b0, OP_TICK, 16'd0, 24'h000000, 0, 1'b0);
        queue_attempt(1'b1, OP_READ, 16'h0000, 24'h7FFFFF, 0, 1'b0);
        queue_attempt(1'b1, OP_READ, 16'h0000, 24'h800000, 4, 1'b0);
        settle_idle();

        // widest timeout, longer half period
        set_regs(32'h000F_FFFF, 32'd4, 32'hFFFF_FFFF);
        queue_attempt(1'b1, OP_READ, 16'h0000, pick_word(), 2, 1'b0);
        settle_idle();

        // long tare, every attempt timing out at once
        set_regs(32'd0, 32'd3, 32'd65536);
        queue_tick(OP_TARE, 1'b1, 16'd24);
        settle_idle();

        // random phases: mostly whole reads and tares, some noise
        rnd_base = items_pushed;
        phase_no = 0;
        while ((items_pushed - rnd_base) < RANDOM_TICKS)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 7)
                timeout = $urandom_range(0, 30);
            else if (sel < 9)
                timeout = $urandom_range(100, 2000);
            else
                timeout = 32'($urandom) & 32'h000F_FFFF;
            sel = $urandom_range(0, 19);
            if (sel < 10)
                half = 32'd1;
            else if (sel < 15)
                half = $urandom_range(2, 3);
            else if (sel < 17)
                half = 32'd0;
            else
                half = $urandom_range(4, 6);
            sel = $urandom_range(0, 5);
            case (sel)
                0: gain = 32'h8000_0000;
                1: gain = 32'h7FFF_FFFF;
                2: gain = 32'd65536;
                3: gain = 32'($urandom_range(0, 2000)) - 32'd1000;
                default: gain = $urandom;
            endcase
            set_regs(timeout, half, gain);

            // one phase runs with no gaps on either side
            calm = (phase_no == 0);

            for (j = 0; j < 4; j++)
            begin
                sel = $urandom_range(0, 19);
                if (sel <= 10)
                begin
                    queue_attempt(1'b1, OP_READ, 16'($urandom), pick_word(),
                                  $urandom_range(0, 4),
                                  (reg_timeout <= 30) && ($urandom_range(0, 5) == 0));
                end
                else if (sel <= 14)
                begin
                    queue_random_tare($urandom_range(1, 4));
                end
                else if (sel <= 17)
                begin
                    // loose ticks, may start or break an operation
                    repeat ($urandom_range(1, 6)) queue_filler(1'($urandom));
                end
                else
                begin
                    queue_tick(($urandom_range(0, 1) != 0) ? OP_TARE : OP_TICK,
                               1'($urandom), 16'h0000);
                end
            end
            settle_idle();
            phase_no++;
        end
        calm = 1'b0;

        while (results_seen != items_pushed)
            @(posedge clk);
        repeat (END_CYCLES) @(posedge clk);
        if (predicted_results.size() != 0)
        begin
            $error("%0d predicted result items never arrived", predicted_results.size());
            fails++;
        end
        if (fails == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
